>>> rtl/hsv_pkg.sv
// shared constants, sector codes and types of the hsv to rgb converter
package hsv_pkg;

    localparam int HUE_W       = 13;
    localparam int LVL_W       = 8;
    localparam int FRAC_W      = 10;
    localparam int SEC_W       = 3;
    localparam int TERM_W      = 18;
    localparam int PROD_W      = 26;
    localparam int PROD_SHIFT  = 6;
    localparam int Y_W         = PROD_W - PROD_SHIFT;
    localparam int APROD_W     = 2 * LVL_W;
    localparam int DIVC_W      = 12;
    localparam int RECIP_W     = 9;
    localparam int RECIP_SHIFT = 20;
    localparam int NUM_STAGES  = 7;

    localparam logic [HUE_W-1:0]   FULL_TURN   = 13'd5760;
    localparam logic [HUE_W-1:0]   SECTOR_SPAN = 13'd960;
    localparam logic [LVL_W-1:0]   LEVEL_MAX   = 8'd255;
    localparam logic [TERM_W-1:0]  BLEND_DEN   = 18'd244800;
    // 244800 / 64
    localparam logic [DIVC_W-1:0]  DIV_REST    = 12'd3825;
    // floor(2^20 / 3825), estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP_REST  = 9'd274;
    // floor(2^16 / 255), estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP_LVL   = 9'd257;

    // hue sectors
    localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

    // load enables of the two divider stages
    typedef struct packed {
        logic est;
        logic fix;
    } div_en_t;

endpackage

>>> rtl/hsv_div3825.sv
// two-stage divide by 3825 using a reciprocal estimate and one correction
module hsv_div3825
    import hsv_pkg::*;
(
    input  logic             aclk,
    input  div_en_t          en,
    input  logic [Y_W-1:0]   y_in,
    output logic [LVL_W-1:0] q_out
);

    localparam int MUL_W = Y_W + RECIP_W;

    logic [MUL_W-1:0] est_prod;
    logic [Y_W-1:0]   y_reg;
    logic [LVL_W-1:0] qe_reg;
    logic [LVL_W-1:0] q_reg;
    logic [LVL_W-1:0] q_next;
    logic [Y_W-1:0]   rem;

    assign est_prod = MUL_W'(y_in) * MUL_W'(RECIP_REST);

    // remainder stays below twice the divisor
    assign rem    = y_reg - Y_W'(qe_reg) * Y_W'(DIV_REST);
    assign q_next = (rem >= Y_W'(DIV_REST)) ? qe_reg + LVL_W'(1) : qe_reg;

    always_ff @(posedge aclk) begin
        if (en.est) begin
            y_reg  <= y_in;
            qe_reg <= est_prod[RECIP_SHIFT +: LVL_W];
        end
        if (en.fix) begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter: seven-stage pipeline with per-stage stall
// a word taken on s_valid/s_ready is registered in each stage in turn before m_valid shows it
// throughput: one word per cycle while the output side is ready; the stages are cut around the multipliers
// (brightness times blend term, reciprocal estimate, correction product)
// a stall holds each full stage and lets empty stages fill, so no word is lost
// reset (aresetn low, synchronous) empties all stages; data registers keep content
module hsv_to_rgb_converter
    import hsv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [HUE_W-1:0] s_hue,
    input  logic [LVL_W-1:0] s_saturation,
    input  logic [LVL_W-1:0] s_brightness,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LVL_W-1:0] m_red,
    output logic [LVL_W-1:0] m_green,
    output logic [LVL_W-1:0] m_blue
);

    // stage control: adv[i] means stage i+1 (vld_reg[i]) may load this cycle
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES:0]   adv;

    always_comb begin
        adv[NUM_STAGES] = m_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                vld_next[i] = (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    // stage 1: fold hue into one turn
    logic [HUE_W-1:0] h1_reg, h1_next;
    logic [LVL_W-1:0] s1_reg, v1_reg;

    // a hue at or past a full turn wraps once
    assign h1_next = (s_hue >= FULL_TURN) ? s_hue - FULL_TURN : s_hue;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            h1_reg <= h1_next;
            s1_reg <= s_saturation;
            v1_reg <= s_brightness;
        end
    end

    // stage 2: sector and fraction, brightness times (255 - s)
    logic [SEC_W-1:0]   sec2_reg, sec2_next;
    logic [FRAC_W-1:0]  f2_reg;
    logic [HUE_W-1:0]   f2_full;
    logic [LVL_W-1:0]   s2_reg, v2_reg;
    logic [APROD_W-1:0] ap2_reg, ap2_next;

    always_comb begin
        priority if (h1_reg >= HUE_W'(5 * SECTOR_SPAN)) begin
            sec2_next = SEC_MAG_RED;
            f2_full   = h1_reg - HUE_W'(5 * SECTOR_SPAN);
        end else if (h1_reg >= HUE_W'(4 * SECTOR_SPAN)) begin
            sec2_next = SEC_BLU_MAG;
            f2_full   = h1_reg - HUE_W'(4 * SECTOR_SPAN);
        end else if (h1_reg >= HUE_W'(3 * SECTOR_SPAN)) begin
            sec2_next = SEC_CYN_BLU;
            f2_full   = h1_reg - HUE_W'(3 * SECTOR_SPAN);
        end else if (h1_reg >= HUE_W'(2 * SECTOR_SPAN)) begin
            sec2_next = SEC_GRN_CYN;
            f2_full   = h1_reg - HUE_W'(2 * SECTOR_SPAN);
        end else if (h1_reg >= SECTOR_SPAN) begin
            sec2_next = SEC_YEL_GRN;
            f2_full   = h1_reg - SECTOR_SPAN;
        end else begin
            sec2_next = SEC_RED_YEL;
            f2_full   = h1_reg;
        end
    end

    assign ap2_next = APROD_W'(v1_reg) * APROD_W'(LEVEL_MAX - s1_reg);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sec2_reg <= sec2_next;
            f2_reg   <= f2_full[FRAC_W-1:0];
            s2_reg   <= s1_reg;
            v2_reg   <= v1_reg;
            ap2_reg  <= ap2_next;
        end
    end

    // stage 3: blend terms and the low estimate of aa
    localparam int AMUL_W = APROD_W + RECIP_W;

    logic [SEC_W-1:0]   sec3_reg;
    logic [LVL_W-1:0]   v3_reg, aae3_reg;
    logic               gry3_reg;
    logic [TERM_W-1:0]  tb3_reg, tc3_reg;
    logic [APROD_W-1:0] ap3_reg;
    logic [FRAC_W-1:0]  g2;
    logic [TERM_W-1:0]  sf2, sg2;
    logic [AMUL_W-1:0]  amul2;

    assign g2    = SECTOR_SPAN[FRAC_W-1:0] - f2_reg;
    assign sf2   = TERM_W'(s2_reg) * TERM_W'(f2_reg);
    assign sg2   = TERM_W'(s2_reg) * TERM_W'(g2);
    assign amul2 = AMUL_W'(ap2_reg) * AMUL_W'(RECIP_LVL);

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            sec3_reg <= sec2_reg;
            v3_reg   <= v2_reg;
            gry3_reg <= (s2_reg == '0);
            tb3_reg  <= BLEND_DEN - sf2;
            tc3_reg  <= BLEND_DEN - sg2;
            ap3_reg  <= ap2_reg;
            aae3_reg <= amul2[APROD_W +: LVL_W];
        end
    end

    // stage 4: brightness times blend terms, aa correction
    logic [SEC_W-1:0]   sec4_reg;
    logic [LVL_W-1:0]   v4_reg, aa4_reg, aa4_next;
    logic               gry4_reg;
    logic [Y_W-1:0]     yb4_reg, yc4_reg;
    logic [PROD_W-1:0]  nb3, nc3;
    logic [APROD_W-1:0] arem3;

    assign nb3 = PROD_W'(v3_reg) * PROD_W'(tb3_reg);
    assign nc3 = PROD_W'(v3_reg) * PROD_W'(tc3_reg);

    // est * 255 as a shift and subtract
    assign arem3    = ap3_reg - ({aae3_reg, LVL_W'(0)} - APROD_W'(aae3_reg));
    assign aa4_next = (arem3 >= APROD_W'(LEVEL_MAX)) ? aae3_reg + LVL_W'(1) : aae3_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            sec4_reg <= sec3_reg;
            v4_reg   <= v3_reg;
            gry4_reg <= gry3_reg;
            aa4_reg  <= aa4_next;
            // dividing by 64 first leaves a divide by 3825
            yb4_reg  <= nb3[PROD_W-1:PROD_SHIFT];
            yc4_reg  <= nc3[PROD_W-1:PROD_SHIFT];
        end
    end

    // stages 5 and 6: the two blend dividers, side data rides alongside
    div_en_t          div_en;
    logic [LVL_W-1:0] bb6, cc6;

    assign div_en.est = adv[4];
    assign div_en.fix = adv[5];

    hsv_div3825 u_div_bb (
        .aclk  (aclk),
        .en    (div_en),
        .y_in  (yb4_reg),
        .q_out (bb6)
    );

    hsv_div3825 u_div_cc (
        .aclk  (aclk),
        .en    (div_en),
        .y_in  (yc4_reg),
        .q_out (cc6)
    );

    logic [SEC_W-1:0] sec5_reg, sec6_reg;
    logic [LVL_W-1:0] v5_reg, v6_reg, aa5_reg, aa6_reg;
    logic             gry5_reg, gry6_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            sec5_reg <= sec4_reg;
            v5_reg   <= v4_reg;
            aa5_reg  <= aa4_reg;
            gry5_reg <= gry4_reg;
        end
        if (adv[5]) begin
            sec6_reg <= sec5_reg;
            v6_reg   <= v5_reg;
            aa6_reg  <= aa5_reg;
            gry6_reg <= gry5_reg;
        end
    end

    // stage 7: route levels to channels, this is the output register
    logic [LVL_W-1:0] red_reg, green_reg, blue_reg;
    logic [LVL_W-1:0] red_next, green_next, blue_next;

    always_comb begin
        if (gry6_reg) begin
            // no saturation means grey
            red_next   = v6_reg;
            green_next = v6_reg;
            blue_next  = v6_reg;
        end else begin
            unique case (sec6_reg)
                SEC_RED_YEL: begin
                    red_next = v6_reg;  green_next = cc6;     blue_next = aa6_reg;
                end
                SEC_YEL_GRN: begin
                    red_next = bb6;     green_next = v6_reg;  blue_next = aa6_reg;
                end
                SEC_GRN_CYN: begin
                    red_next = aa6_reg; green_next = v6_reg;  blue_next = cc6;
                end
                SEC_CYN_BLU: begin
                    red_next = aa6_reg; green_next = bb6;     blue_next = v6_reg;
                end
                SEC_BLU_MAG: begin
                    red_next = cc6;     green_next = aa6_reg; blue_next = v6_reg;
                end
                default: begin
                    // magenta to red, and codes that never occur
                    red_next = v6_reg;  green_next = aa6_reg; blue_next = bb6;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

    // checks

    // an empty first stage always takes a word, even with the output stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_ready)
        else $error("first stage empty but input not ready");

    // corrected aa never exceeds brightness
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[3] |-> (aa4_reg <= v4_reg))
        else $error("aa above brightness");

    // corrected blend quotients never exceed brightness
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5] |-> (bb6 <= v6_reg && cc6 <= v6_reg))
        else $error("blend level above brightness");

    // a grey word leaves with three equal channels
    assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[5] && adv[6] && gry6_reg) |=> (m_red == m_green && m_green == m_blue))
        else $error("grey word with unequal channels");

endmodule
